// ===== rtl/btp_pkg.sv =====
// Shared types and constants of the BER TLV stream parser.
`default_nettype none
package btp_pkg;

   localparam int DEF_MAX_DEPTH      = 16;
   localparam int DEF_MAX_LEN_OCTETS = 4;
   localparam int DEF_TAG_BITS       = 28;

   localparam int TAG_OUT_W = 28;
   localparam int LEN_OUT_W = 32;
   localparam int CNT_OUT_W = 5;

   typedef enum logic [2:0] {
      KIND_HEADER  = 3'd0,
      KIND_HDONE   = 3'd1,
      KIND_CONTENT = 3'd2,
      KIND_EOC     = 3'd3,
      KIND_ERROR   = 3'd4,
      KIND_IGNORED = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_HDR_LIMIT = 3'd1,
      ERR_LEN_OCTS  = 3'd2,
      ERR_TAG_LONG  = 3'd3,
      ERR_TOO_DEEP  = 3'd4,
      ERR_OVERRUN   = 3'd5
   } err_type;

   typedef enum logic [2:0] {
      PH_TAG  = 3'd0,
      PH_TAGX = 3'd1,
      PH_LEN1 = 3'd2,
      PH_LENX = 3'd3,
      PH_DATA = 3'd4,
      PH_DONE = 3'd5,
      PH_ERR  = 3'd6
   } phase_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_POP  = 1'b1
   } ctrl_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic push_indef;
   } stack_op_type;

endpackage
`default_nettype wire

// ===== rtl/btp_cell.sv =====
// One entry of the shifting container stack.
`default_nettype none
module btp_cell #(
   parameter int W = 33
) (
   input  wire                   clock,
   input  btp_pkg::stack_op_type op,
   input  wire  [W-1:0]          up_end,
   input  wire                   up_indef,
   input  wire  [W-1:0]          down_end,
   input  wire                   down_indef,
   output logic [W-1:0]          end_q,
   output logic                  indef_q
);
   import btp_pkg::*;

   logic [W-1:0] end_ff, end_in;
   logic         indef_ff, indef_in;

   always_comb begin
      end_in   = end_ff;
      indef_in = indef_ff;
      if (op.push) begin
         end_in   = up_end;
         indef_in = up_indef;
      end else if (op.pop) begin
         end_in   = down_end;
         indef_in = down_indef;
      end
   end

   always_ff @(posedge clock) begin
      end_ff   <= end_in;
      indef_ff <= indef_in;
   end

   assign end_q   = end_ff;
   assign indef_q = indef_ff;
endmodule
`default_nettype wire

// ===== rtl/btp_stack.sv =====
// Row of stack cells; the innermost open container sits in cell zero.
`default_nettype none
module btp_stack #(
   parameter int DEPTH = 16,
   parameter int W     = 33
) (
   input  wire                   clock,
   input  btp_pkg::stack_op_type op,
   input  wire  [W-1:0]          push_end,
   output logic [W-1:0]          top_end,
   output logic                  top_indef
);
   import btp_pkg::*;

   logic [W-1:0] end_q   [DEPTH];
   logic         indef_q [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [W-1:0] up_e, dn_e;
      logic         up_i, dn_i;
      if (i == 0) begin : g_head
         assign up_e = push_end;
         assign up_i = op.push_indef;
      end else begin : g_body
         assign up_e = end_q[i-1];
         assign up_i = indef_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign dn_e = end_q[i];
         assign dn_i = indef_q[i];
      end else begin : g_mid
         assign dn_e = end_q[i+1];
         assign dn_i = indef_q[i+1];
      end
      btp_cell #(.W(W)) u_cell (
         .clock      (clock),
         .op         (op),
         .up_end     (up_e),
         .up_indef   (up_i),
         .down_end   (dn_e),
         .down_indef (dn_i),
         .end_q      (end_q[i]),
         .indef_q    (indef_q[i])
      );
   end

   assign top_end   = end_q[0];
   assign top_indef = indef_q[0];
endmodule
`default_nettype wire

// ===== rtl/ber_tlv_stream_parser.sv =====
// Top level of the BER TLV stream parser.
//
// Bytes enter on the req_ channel (req_in_byte, req_first) and each gives
// exactly one result beat on the rsp_ channel: its role, the tag and
// length decoded so far, the nesting depth, the echoed byte, how many
// containers close with it and a sticky error code.
// A byte is parsed in the cycle it is accepted. Unless it ends an element,
// its result is shown from the next cycle. When it ends an element, the
// container stack (a row of cells that shift on push and pop) pops one
// closing container per cycle, and the result appears once the cascade
// is over. A new byte is taken in the cycle the previous result is taken,
// so with a ready receiver bytes are taken back to back, but no byte is
// taken while the stack pops after a byte that ends an element.
// When the receiver stalls, the result holds and req_ready stays low.
// Reset empties the stack, clears the error, sets the budget register
// (csr_we / csr_wdata) to all ones and starts a new element.
`default_nettype none
module ber_tlv_stream_parser #(
   parameter int MAX_DEPTH      = btp_pkg::DEF_MAX_DEPTH,
   parameter int MAX_LEN_OCTETS = btp_pkg::DEF_MAX_LEN_OCTETS,
   parameter int TAG_BITS       = btp_pkg::DEF_TAG_BITS
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_we,
   input  wire  [31:0] csr_wdata,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [7:0]  req_in_byte,
   input  wire         req_first,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [1:0]  rsp_tag_class,
   output logic        rsp_constructed,
   output logic [27:0] rsp_tag_number,
   output logic [31:0] rsp_content_length,
   output logic        rsp_indefinite,
   output logic [4:0]  rsp_nest_depth,
   output logic [7:0]  rsp_data_out,
   output logic [4:0]  rsp_closed_count,
   output logic [2:0]  rsp_error_code
);
   import btp_pkg::*;

   localparam int POS_W   = 33;
   localparam int LEN_W   = 8 * MAX_LEN_OCTETS;
   localparam int CMP_W   = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;
   localparam int LVL_W   = $clog2(MAX_DEPTH + 1);
   localparam int CLOSE_W = $clog2(MAX_DEPTH + 2);
   localparam int OCT_W   = $clog2(MAX_LEN_OCTETS + 1);

   ctrl_type             state_ff, state_in;
   phase_type            phase_ff, phase_in;
   err_type              err_ff, err_in;
   logic [31:0]          limit_ff, limit_in;
   logic [POS_W-1:0]     pos_ff, pos_in, pos1_ff, pos1_in;
   logic [LVL_W-1:0]     level_ff, level_in;
   logic [TAG_BITS-1:0]  tag_ff, tag_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [OCT_W-1:0]     octs_ff, octs_in;
   logic [POS_W-1:0]     primend_ff, primend_in;
   logic [1:0]           cls_ff, cls_in;
   logic                 cons_ff, cons_in, indef_ff, indef_in, zero_ff, zero_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   kind_type             rsp_kind_ff, rsp_kind_in;
   logic [1:0]           rsp_cls_ff, rsp_cls_in;
   logic                 rsp_cons_ff, rsp_cons_in, rsp_indef_ff, rsp_indef_in;
   logic [TAG_BITS-1:0]  rsp_tag_ff, rsp_tag_in;
   logic [LEN_W-1:0]     rsp_len_ff, rsp_len_in;
   logic [LVL_W-1:0]     rsp_depth_ff, rsp_depth_in;
   logic [7:0]           rsp_data_ff, rsp_data_in;
   logic [CLOSE_W-1:0]   rsp_closed_ff, rsp_closed_in;
   err_type              rsp_err_ff, rsp_err_in;

   stack_op_type         op;
   logic [POS_W-1:0]     push_end, top_end;
   logic                 top_indef;

   phase_type            e_phase;
   logic [POS_W-1:0]     e_pos, e_pos1, bound, room;
   logic [LVL_W-1:0]     e_level;
   err_type              e_err, fail;
   kind_type             kind;
   logic                 done, fin, cascade;
   logic [CLOSE_W-1:0]   closed_base;
   logic [OCT_W-1:0]     octs_dec;
   logic [6:0]           nocts;
   logic [7:0]           b;

   btp_stack #(.DEPTH(MAX_DEPTH), .W(POS_W)) u_stack (
      .clock     (clock),
      .op        (op),
      .push_end  (push_end),
      .top_end   (top_end),
      .top_indef (top_indef)
   );

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign cascade   = (level_ff != '0) && !top_indef && (top_end == pos_ff);
   assign b         = req_in_byte;
   assign nocts     = req_in_byte[6:0];

   always_comb begin
      state_in = state_ff;  phase_in = phase_ff;  err_in = err_ff;
      limit_in = limit_ff;  pos_in = pos_ff;  pos1_in = pos1_ff;
      level_in = level_ff;  tag_in = tag_ff;  len_in = len_ff;
      octs_in = octs_ff;  primend_in = primend_ff;  cls_in = cls_ff;
      cons_in = cons_ff;  indef_in = indef_ff;  zero_in = zero_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_kind_in = rsp_kind_ff;  rsp_cls_in = rsp_cls_ff;
      rsp_cons_in = rsp_cons_ff;  rsp_indef_in = rsp_indef_ff;
      rsp_tag_in = rsp_tag_ff;  rsp_len_in = rsp_len_ff;
      rsp_depth_in = rsp_depth_ff;  rsp_data_in = rsp_data_ff;
      rsp_closed_in = rsp_closed_ff;  rsp_err_in = rsp_err_ff;
      op = '0;  push_end = '0;
      e_phase = req_first ? PH_TAG : phase_ff;
      e_pos   = req_first ? '0 : pos_ff;
      e_pos1  = req_first ? POS_W'(1) : pos1_ff;
      e_level = req_first ? '0 : level_ff;
      e_err   = req_first ? ERR_NONE : err_ff;
      bound   = (e_level != '0) ? top_end : POS_W'(limit_ff);
      room    = bound - e_pos1;
      fail = ERR_NONE;  kind = KIND_HEADER;  done = 1'b0;  fin = 1'b0;
      closed_base = '0;
      octs_dec = (octs_ff != '0) ? octs_ff - OCT_W'(1) : '0;

      if (csr_we) limit_in = csr_wdata;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               phase_in = e_phase;  pos_in = e_pos;  pos1_in = e_pos1;
               level_in = e_level;  err_in = e_err;
               if (e_phase == PH_DONE) begin
                  kind = KIND_IGNORED;
               end else if (e_phase == PH_ERR) begin
                  kind = KIND_IGNORED;
               end else begin
                  pos_in  = e_pos1;
                  pos1_in = e_pos1 + POS_W'(1);
                  unique case (e_phase)
                     PH_TAG: begin
                        cls_in = b[7:6];  cons_in = b[5];  zero_in = (b == 8'h00);
                        indef_in = 1'b0;  len_in = '0;
                        tag_in = TAG_BITS'(b[4:0]);
                        if (e_pos1 >= bound) fail = ERR_HDR_LIMIT;
                        else if (b[4:0] == 5'h1f) begin
                           tag_in = '0;  phase_in = PH_TAGX;
                        end else phase_in = PH_LEN1;
                     end
                     PH_TAGX: begin
                        if (e_pos1 >= bound) fail = ERR_HDR_LIMIT;
                        else if (tag_ff[TAG_BITS-1 -: 7] != 7'd0) fail = ERR_TAG_LONG;
                        else begin
                           tag_in = TAG_BITS'({tag_ff, b[6:0]});
                           if (!b[7]) phase_in = PH_LEN1;
                        end
                     end
                     PH_LEN1: begin
                        if (zero_ff && b == 8'h00 && e_level != '0 && top_indef) begin
                           if (e_pos1 > bound) fail = ERR_HDR_LIMIT;
                           else begin
                              // close the innermost indefinite container
                              kind = KIND_EOC;  op.pop = 1'b1;
                              level_in = e_level - LVL_W'(1);
                              closed_base = CLOSE_W'(1);  fin = 1'b1;
                           end
                        end else if (b[7]) begin
                           if (nocts == 7'd0) begin
                              indef_in = 1'b1;  done = 1'b1;
                           end else if (nocts > 7'(MAX_LEN_OCTETS)) fail = ERR_LEN_OCTS;
                           else if (e_pos1 >= bound) fail = ERR_HDR_LIMIT;
                           else begin
                              octs_in = OCT_W'(nocts);  len_in = '0;  phase_in = PH_LENX;
                           end
                        end else begin
                           len_in = LEN_W'(b);  done = 1'b1;
                        end
                     end
                     PH_LENX: begin
                        len_in  = LEN_W'({len_ff, b});
                        octs_in = octs_dec;
                        if (octs_dec != '0) begin
                           if (e_pos1 >= bound) fail = ERR_HDR_LIMIT;
                        end else done = 1'b1;
                     end
                     default: begin
                        kind = KIND_CONTENT;
                        if (e_pos1 >= primend_ff) fin = 1'b1;
                     end
                  endcase

                  if (done) begin
                     kind = KIND_HDONE;
                     if (indef_in) begin
                        if (!cons_in) fail = ERR_LEN_OCTS;
                        else if (e_pos1 >= bound) fail = ERR_HDR_LIMIT;
                        else if (e_level >= LVL_W'(MAX_DEPTH)) fail = ERR_TOO_DEEP;
                        else begin
                           op.push = 1'b1;  op.push_indef = 1'b1;  push_end = bound;
                           level_in = e_level + LVL_W'(1);  phase_in = PH_TAG;
                        end
                     end else if (e_pos1 > bound) fail = ERR_HDR_LIMIT;
                     else if (CMP_W'(len_in) > CMP_W'(room)) fail = ERR_OVERRUN;
                     else if (cons_in) begin
                        if (len_in == '0) begin
                           closed_base = CLOSE_W'(1);  fin = 1'b1;
                        end else if (e_level >= LVL_W'(MAX_DEPTH)) fail = ERR_TOO_DEEP;
                        else begin
                           op.push = 1'b1;  push_end = e_pos1 + POS_W'(len_in);
                           level_in = e_level + LVL_W'(1);  phase_in = PH_TAG;
                        end
                     end else if (len_in == '0) fin = 1'b1;
                     else begin
                        primend_in = e_pos1 + POS_W'(len_in);  phase_in = PH_DATA;
                     end
                  end

                  if (fail != ERR_NONE) begin
                     kind = KIND_ERROR;  phase_in = PH_ERR;  err_in = fail;
                     fin = 1'b0;  op = '0;  level_in = e_level;
                  end
               end

               rsp_kind_in   = kind;
               rsp_depth_in  = e_level;
               rsp_data_in   = b;
               rsp_closed_in = closed_base;
               rsp_err_in    = (e_phase == PH_ERR) ? e_err : fail;
               if (kind == KIND_ERROR || kind == KIND_IGNORED) begin
                  rsp_cls_in = '0;  rsp_cons_in = 1'b0;  rsp_tag_in = '0;
                  rsp_len_in = '0;  rsp_indef_in = 1'b0;
               end else begin
                  rsp_cls_in = cls_in;  rsp_cons_in = cons_in;  rsp_tag_in = tag_in;
                  rsp_len_in = len_in;  rsp_indef_in = indef_in;
               end
               if (fin) state_in = ST_POP;
               else rsp_valid_in = 1'b1;
            end
         end
         ST_POP: begin
            // pop one definite container ending at this position per cycle
            if (cascade) begin
               op.pop = 1'b1;
               level_in = level_ff - LVL_W'(1);
               rsp_closed_in = rsp_closed_ff + CLOSE_W'(1);
            end else begin
               phase_in = (level_ff == '0) ? PH_DONE : PH_TAG;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;  phase_ff <= PH_TAG;  err_ff <= ERR_NONE;
         limit_ff <= '1;  pos_ff <= '0;  pos1_ff <= POS_W'(1);
         level_ff <= '0;  rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;  phase_ff <= phase_in;  err_ff <= err_in;
         limit_ff <= limit_in;  pos_ff <= pos_in;  pos1_ff <= pos1_in;
         level_ff <= level_in;  rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;  len_ff <= len_in;  octs_ff <= octs_in;
      primend_ff <= primend_in;  cls_ff <= cls_in;  cons_ff <= cons_in;
      indef_ff <= indef_in;  zero_ff <= zero_in;
      rsp_kind_ff <= rsp_kind_in;  rsp_cls_ff <= rsp_cls_in;
      rsp_cons_ff <= rsp_cons_in;  rsp_indef_ff <= rsp_indef_in;
      rsp_tag_ff <= rsp_tag_in;  rsp_len_ff <= rsp_len_in;
      rsp_depth_ff <= rsp_depth_in;  rsp_data_ff <= rsp_data_in;
      rsp_closed_ff <= rsp_closed_in;  rsp_err_ff <= rsp_err_in;
   end

   logic [TAG_BITS+TAG_OUT_W-1:0] tag_wide;
   logic [LEN_W+LEN_OUT_W-1:0]    len_wide;
   logic [LVL_W+CNT_OUT_W-1:0]    depth_wide;
   logic [CLOSE_W+CNT_OUT_W-1:0]  closed_wide;

   assign tag_wide    = {{TAG_OUT_W{1'b0}}, rsp_tag_ff};
   assign len_wide    = {{LEN_OUT_W{1'b0}}, rsp_len_ff};
   assign depth_wide  = {{CNT_OUT_W{1'b0}}, rsp_depth_ff};
   assign closed_wide = {{CNT_OUT_W{1'b0}}, rsp_closed_ff};

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_tag_class      = rsp_cls_ff;
   assign rsp_constructed    = rsp_cons_ff;
   assign rsp_tag_number     = tag_wide[TAG_OUT_W-1:0];
   assign rsp_content_length = len_wide[LEN_OUT_W-1:0];
   assign rsp_indefinite     = rsp_indef_ff;
   assign rsp_nest_depth     = depth_wide[CNT_OUT_W-1:0];
   assign rsp_data_out       = rsp_data_ff;
   assign rsp_closed_count   = closed_wide[CNT_OUT_W-1:0];
   assign rsp_error_code     = rsp_err_ff;
endmodule
`default_nettype wire

// ===== rtl/btp_checker.sv =====
// Port-level checks of the parser, bound to the top level.
`default_nettype none
module btp_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [2:0]  rsp_kind,
   input wire [1:0]  rsp_tag_class,
   input wire [27:0] rsp_tag_number,
   input wire [4:0]  rsp_closed_count,
   input wire [2:0]  rsp_error_code
);
   import btp_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_error_code))
      else $error("result beat changed while stalled");

   a_no_take: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("byte taken while result stalled");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ERROR |-> rsp_error_code != ERR_NONE)
      else $error("error beat without code");

   a_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ERROR || rsp_kind == KIND_IGNORED) |->
      rsp_tag_class == 2'd0 && rsp_tag_number == 28'd0 && rsp_closed_count == 5'd0)
      else $error("error or ignored beat carries element fields");
endmodule

bind ber_tlv_stream_parser btp_checker u_btp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_kind         (rsp_kind),
   .rsp_tag_class    (rsp_tag_class),
   .rsp_tag_number   (rsp_tag_number),
   .rsp_closed_count (rsp_closed_count),
   .rsp_error_code   (rsp_error_code)
);
`default_nettype wire
